@@ rtl/core/gcpe_pkg.sv @@
// Package with the constants, types and helper functions of the grid cell pop effect block.
package gcpe_pkg;

  localparam logic [31:0] LcgMul   = 32'd1103515245;
  localparam logic [31:0] LcgAdd   = 32'd12345;
  localparam logic [31:0] RowHash  = 32'd2654435761;
  localparam logic [31:0] ColHash  = 32'd2246822519;

  localparam int unsigned MaxRows  = 256;
  localparam int unsigned MaxCols  = 256;

  // Reciprocals for the constant divisions; the dividend is pre-shifted right by two bits.
  localparam logic [29:0] Recip125 = 30'd549755814;  // ceil(2^36 / 125)
  localparam int unsigned Shift125 = 36;
  localparam logic [29:0] Recip25  = 30'd687194768;  // ceil(2^34 / 25)
  localparam int unsigned Shift25  = 34;

  localparam logic [31:0] StartSpan    = 32'd500;
  localparam logic [31:0] ColorSpan    = 32'd100;
  localparam logic [6:0]  AltBelow     = 7'd45;
  localparam logic [9:0]  FadeMin      = 10'd300;
  localparam logic [10:0] FullLimit    = 11'd165;
  localparam logic [10:0] PartialLimit = 11'd330;

  typedef enum logic [2:0] {
    RegHashSeed     = 3'd0,
    RegCellPitch    = 3'd1,
    RegFullSize     = 3'd2,
    RegFullInset    = 3'd3,
    RegPartialSize  = 3'd4,
    RegPartialInset = 3'd5,
    RegPrimaryColor = 3'd6,
    RegAltColor     = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] hash_seed;
    logic [7:0]  cell_pitch;
    logic [7:0]  full_side;
    logic [7:0]  full_inset;
    logic [7:0]  partial_side;
    logic [7:0]  partial_inset;
    logic [7:0]  primary_color;
    logic [7:0]  alt_color;
  } cfg_t;

  // Fields that ride along the pipeline next to the random values.
  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [9:0]  progress;
    logic        eligible;
  } carry_t;

  // One step of the 31-bit linear congruential generator.
  function automatic logic [30:0] lcg_advance(input logic [31:0] s);
    logic [31:0] t;
    t = s * LcgMul + LcgAdd;
    return t[30:0];
  endfunction

  // Position plus inset, saturated to 16 bits.
  function automatic logic [15:0] sat_add(input logic [15:0] p, input logic [7:0] inset);
    logic [16:0] sum;
    sum = {1'b0, p} + {9'd0, inset};
    return sum[16] ? 16'hffff : sum[15:0];
  endfunction

endpackage

@@ rtl/core/gcpe_cfg_regs.sv @@
// Configuration register file of the grid cell pop effect block.
module gcpe_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_addr_i,
  input  logic [31:0]        cfg_data_i,
  output gcpe_pkg::cfg_t     cfg_o
);

  gcpe_pkg::cfg_t cfg_q, cfg_d;
  gcpe_pkg::cfg_reg_e addr;

  assign cfg_ready_o = 1'b1;
  assign addr = gcpe_pkg::cfg_reg_e'(cfg_addr_i);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (addr)
        gcpe_pkg::RegHashSeed:     cfg_d.hash_seed     = cfg_data_i;
        gcpe_pkg::RegCellPitch:    cfg_d.cell_pitch    = cfg_data_i[7:0];
        gcpe_pkg::RegFullSize:     cfg_d.full_side     = cfg_data_i[7:0];
        gcpe_pkg::RegFullInset:    cfg_d.full_inset    = cfg_data_i[7:0];
        gcpe_pkg::RegPartialSize:  cfg_d.partial_side  = cfg_data_i[7:0];
        gcpe_pkg::RegPartialInset: cfg_d.partial_inset = cfg_data_i[7:0];
        gcpe_pkg::RegPrimaryColor: cfg_d.primary_color = cfg_data_i[7:0];
        gcpe_pkg::RegAltColor:     cfg_d.alt_color     = cfg_data_i[7:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hash_seed     <= 32'd0;
      cfg_q.cell_pitch    <= 8'd8;
      cfg_q.full_side     <= 8'd6;
      cfg_q.full_inset    <= 8'd1;
      cfg_q.partial_side  <= 8'd4;
      cfg_q.partial_inset <= 8'd2;
      cfg_q.primary_color <= 8'd255;
      cfg_q.alt_color     <= 8'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/grid_cell_pop_effect.sv @@
// Top level of the grid cell pop effect block: a five-stage pipeline, one cell per cycle.
//
// Usage: each request on the slave stream names one grid cell with the frame progress
// and fade level; the master stream returns one result per request, in order. The flags
// draw_enable and is_full travel in m_axis_tuser, the rectangle and color in tdata.
// A hidden cell returns draw_enable low and every other field zero.
// Configuration registers are written over the cfg channel (index, data), which is
// always ready; write them only while no request is in flight.
// An accepted request passes through the stage registers to the master side: hash, first
// generator step, second step with the start-time quotient, start-time remainder with the
// color quotient, and the decision stage with the color remainder and output register.
// The generator multipliers (32 by 32, low word) and the reciprocal multipliers set the
// stage depth. Throughput is one request per cycle while the receiver is ready. Every
// stage has its own valid bit, and a stage loads whenever it is empty or the stage after
// it moves, so bubbles are squeezed out while the receiver stalls; a full pipeline holds
// its contents without loss. Reset clears all valid bits and loads the register defaults.
module grid_cell_pop_effect (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream, tdata: cell_row[7:0], cell_col[15:8], frame_progress[25:16],
  // fade_level[35:26], zero fill [39:36].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  // Master stream, tdata: rect_x[15:0], rect_y[31:16], rect_side[39:32],
  // fill_color[47:40].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,
  // Master tuser: draw_enable[0], is_full[1].
  output logic [1:0]  m_axis_tuser,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i
);

  gcpe_pkg::cfg_t cfg;

  gcpe_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Unpack the request.
  logic [7:0] in_row, in_col;
  logic [9:0] in_prog, in_fade;
  assign in_row  = s_axis_tdata[7:0];
  assign in_col  = s_axis_tdata[15:8];
  assign in_prog = s_axis_tdata[25:16];
  assign in_fade = s_axis_tdata[35:26];

  // Stage valid bits and the ready chain: a stage may load when it is empty or drains.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  assign rdy5 = !v5_q || m_axis_tready;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // Stage 1: cell hash, pixel positions, grid and fade checks.
  logic [31:0] s1_hash_q, s1_hash_d;
  gcpe_pkg::carry_t c1_q, c1_d;

  always_comb begin
    logic [31:0] row_mix, col_mix;
    logic [8:0]  row_ext, col_ext;
    row_mix = {24'd0, in_row} * gcpe_pkg::RowHash;
    col_mix = {24'd0, in_col} * gcpe_pkg::ColHash;
    row_ext = {1'b0, in_row};
    col_ext = {1'b0, in_col};
    s1_hash_d = row_mix ^ col_mix ^ cfg.hash_seed;
    c1_d.pos_x    = {8'd0, in_col} * {8'd0, cfg.cell_pitch};
    c1_d.pos_y    = {8'd0, in_row} * {8'd0, cfg.cell_pitch};
    c1_d.progress = in_prog;
    // A cell outside the grid or below the fade threshold is never drawn.
    c1_d.eligible = (row_ext < 9'(gcpe_pkg::MaxRows)) && (col_ext < 9'(gcpe_pkg::MaxCols))
                    && (in_fade >= gcpe_pkg::FadeMin);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_hash_q <= s1_hash_d;
      c1_q      <= c1_d;
    end
  end

  // Stage 2: first generator value.
  logic [30:0] s2_first_q;
  gcpe_pkg::carry_t c2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_first_q <= gcpe_pkg::lcg_advance(s1_hash_q);
      c2_q       <= c1_q;
    end
  end

  // Stage 3: second generator value, and the quotient of the first by 500.
  // first / 500 = (first >> 2) / 125, done as a multiply by the scaled reciprocal.
  logic [30:0] s3_first_q, s3_second_q;
  logic [22:0] s3_q500_q, s3_q500_d;
  gcpe_pkg::carry_t c3_q;

  always_comb begin
    logic [58:0] prod;
    prod = {30'd0, s2_first_q[30:2]} * {29'd0, gcpe_pkg::Recip125};
    s3_q500_d = prod[gcpe_pkg::Shift125 +: 23];
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      s3_first_q  <= s2_first_q;
      s3_second_q <= gcpe_pkg::lcg_advance({1'b0, s2_first_q});
      s3_q500_q   <= s3_q500_d;
      c3_q        <= c2_q;
    end
  end

  // Stage 4: start time (first mod 500) and the quotient of the second by 100.
  logic [8:0]  s4_start_q, s4_start_d;
  logic [30:0] s4_second_q;
  logic [24:0] s4_q100_q, s4_q100_d;
  gcpe_pkg::carry_t c4_q;

  always_comb begin
    logic [31:0] back;
    logic [31:0] diff;
    logic [58:0] prod;
    back = {9'd0, s3_q500_q} * gcpe_pkg::StartSpan;
    diff = {1'b0, s3_first_q} - back;
    s4_start_d = diff[8:0];
    prod = {30'd0, s3_second_q[30:2]} * {29'd0, gcpe_pkg::Recip25};
    s4_q100_d = prod[gcpe_pkg::Shift25 +: 25];
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      s4_start_q  <= s4_start_d;
      s4_second_q <= s3_second_q;
      s4_q100_q   <= s4_q100_d;
      c4_q        <= c3_q;
    end
  end

  // Stage 5: color remainder, timing window, and the output register.
  logic        draw_q, draw_d;
  logic        full_q, full_d;
  logic [15:0] rect_x_q, rect_x_d, rect_y_q, rect_y_d;
  logic [7:0]  side_q, side_d, color_q, color_d;

  always_comb begin
    logic [31:0] back;
    logic [31:0] diff;
    logic [6:0]  color_rem;
    logic [10:0] elapsed;
    logic [7:0]  inset;
    back = {7'd0, s4_q100_q} * gcpe_pkg::ColorSpan;
    diff = {1'b0, s4_second_q} - back;
    color_rem = diff[6:0];
    // Signed difference; a negative value shows up with the top bit set.
    elapsed = {1'b0, c4_q.progress} - {2'b00, s4_start_q};
    draw_d = c4_q.eligible && !elapsed[10] && (elapsed < gcpe_pkg::PartialLimit);
    full_d = elapsed < gcpe_pkg::FullLimit;
    inset  = full_d ? cfg.full_inset : cfg.partial_inset;
    side_d = full_d ? cfg.full_side : cfg.partial_side;
    color_d = (color_rem < gcpe_pkg::AltBelow) ? cfg.alt_color : cfg.primary_color;
    rect_x_d = gcpe_pkg::sat_add(c4_q.pos_x, inset);
    rect_y_d = gcpe_pkg::sat_add(c4_q.pos_y, inset);
    // A hidden cell reports all fields as zero.
    if (!draw_d) begin
      full_d   = 1'b0;
      side_d   = 8'd0;
      color_d  = 8'd0;
      rect_x_d = 16'd0;
      rect_y_d = 16'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      draw_q   <= draw_d;
      full_q   <= full_d;
      rect_x_q <= rect_x_d;
      rect_y_q <= rect_y_d;
      side_q   <= side_d;
      color_q  <= color_d;
    end
  end

  assign m_axis_tvalid = v5_q;
  assign m_axis_tdata  = {color_q, side_q, rect_y_q, rect_x_q};
  assign m_axis_tuser  = {full_q, draw_q};

endmodule
